[rtl/core/catrom_pkg.sv]
// Shared types, constants and rounding helpers for the Catmull-Rom position core.
`default_nettype none
package catrom_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned HornW  = 38;
  localparam int unsigned UW     = 17;
  localparam int unsigned ProdW  = HornW + UW + 1;
  localparam int unsigned NumAx  = 3;
  localparam logic [UW-1:0] QOne = 17'h10000;
  localparam logic [0:0] ReqWrite = 1'b0;
  localparam logic [0:0] ReqEval  = 1'b1;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [HornW-1:0]  horn_t;
  typedef logic signed [ProdW-1:0]  prod_t;

  function automatic horn_t round_q16(input prod_t m);
    prod_t r;
    begin
      r = (m + prod_t'(32768)) >>> 16;
      return r[HornW-1:0];
    end
  endfunction

  function automatic coord_t sat_half(input horn_t h);
    horn_t v;
    begin
      v = (h + horn_t'(1)) >>> 1;
      if (v > horn_t'(64'sd2147483647)) begin
        return coord_t'(32'sh7fffffff);
      end else if (v < -horn_t'(64'sd2147483648)) begin
        return coord_t'(32'sh80000000);
      end else begin
        return v[CoordW-1:0];
      end
    end
  endfunction

endpackage
`default_nettype wire

[rtl/core/catmull_rom_spline_position_core.sv]
// Top level: uniform Catmull-Rom spline position pipeline over a control point store.
//
//  channel   direction  ports                         contents
//  s_axis    in         s_tvalid/tready/tdata/tuser   point write or evaluate request
//  m_axis    out        m_tvalid/tready/tdata         interpolated point
//  cfg       in         cfg_valid/ready/data          point_count register
//
// An evaluate request passes eight register stages from acceptance to result; one can enter
// every cycle unless m_tready stalls. The three Horner multiply stages set the depth.
// Write requests update the store at acceptance and produce no result.
// Reset clears the valid bits and sets point_count to four; the store is not cleared.
// Each full stage holds while the next one is full and stalled, so bubbles close up.
`default_nettype none
module catmull_rom_spline_position_core #(
  parameter int unsigned MAX_POINTS = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // point_index[3:0], point_x[35:4], point_y[67:36], point_z[99:68],
  // t_param[116:100], zero[119:117]
  input  wire logic [119:0] s_tdata,
  // req_type[0]
  input  wire logic [0:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // out_x[31:0], out_y[63:32], out_z[95:64]
  output logic [95:0]       m_tdata,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [4:0]   cfg_data
);

  localparam int unsigned IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned GW = catrom_pkg::UW + CW;
  localparam int unsigned NS = 8;
  localparam int unsigned UW = catrom_pkg::UW;
  localparam int unsigned NA = catrom_pkg::NumAx;

  logic [4:0] point_count_q;
  logic [NS:1] v_q;
  logic [NS+1:1] en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_count_q <= 5'd4;
    end else if (cfg_valid) begin
      point_count_q <= cfg_data;
    end
  end

  // Segment and local parameter.
  logic [CW-1:0] count_c, segs_c;
  logic [GW-1:0] g_c, ug_c;
  logic [GW-16-1:0] seg_raw;
  logic [IW-1:0] seg_c, i0_c, i1_c, i2_c, i3_c;
  logic [UW-1:0] u_c;
  logic [UW-1:0] t_in;

  assign t_in = s_tdata[116:100];

  always_comb begin
    if (point_count_q < 5'd4) begin
      count_c = CW'(4);
    end else if (32'(point_count_q) > MAX_POINTS) begin
      count_c = CW'(MAX_POINTS);
    end else begin
      count_c = CW'(point_count_q);
    end
    segs_c  = count_c - CW'(1);
    g_c     = GW'(t_in) * GW'(segs_c);
    seg_raw = g_c[GW-1:16];
    if (seg_raw > (GW-16)'(segs_c - CW'(1))) begin
      seg_c = IW'(segs_c - CW'(1));
    end else begin
      seg_c = IW'(seg_raw);
    end
    ug_c = g_c - (GW'(seg_c) << 16);
    if (ug_c > GW'(catrom_pkg::QOne)) begin
      u_c = catrom_pkg::QOne;
    end else begin
      u_c = ug_c[UW-1:0];
    end
    i1_c = seg_c;
    i2_c = seg_c + IW'(1);
    i0_c = (seg_c == '0) ? seg_c : seg_c - IW'(1);
    i3_c = ((CW + 1)'(seg_c) + (CW + 1)'(2) >= (CW + 1)'(count_c)) ? i2_c : seg_c + IW'(2);
  end

  // Handshake chain.
  always_comb begin
    en[NS+1] = m_tready;
    for (int k = NS; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign s_tready = en[1];

  logic acc_c;
  assign acc_c = s_tvalid && s_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) begin
        v_q[1] <= s_tvalid && (s_tuser == catrom_pkg::ReqEval);
      end
      for (int k = 2; k <= NS; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // Two copies of the store, each with two read ports.
  logic [95:0] mem_a_q [MAX_POINTS];
  logic [95:0] mem_b_q [MAX_POINTS];
  logic [95:0] rd0_q, rd1_q, rd2_q, rd3_q;
  logic [UW-1:0] u1_q;
  logic [IW-1:0] wr_addr;

  assign wr_addr = IW'(s_tdata[3:0]);

  always_ff @(posedge clk_i) begin
    if (acc_c && (s_tuser == catrom_pkg::ReqWrite) && (32'(s_tdata[3:0]) < MAX_POINTS)) begin
      mem_a_q[wr_addr] <= s_tdata[99:4];
      mem_b_q[wr_addr] <= s_tdata[99:4];
    end
    if (en[1]) begin
      rd0_q <= mem_a_q[i0_c];
      rd1_q <= mem_a_q[i1_c];
      rd2_q <= mem_b_q[i2_c];
      rd3_q <= mem_b_q[i3_c];
      u1_q  <= u_c;
    end
  end

  // Horner pipeline.
  catrom_pkg::horn_t e3_q [NA], e2_2_q [NA], e1_2_q [NA], e0_2_q [NA];
  catrom_pkg::prod_t m3_q [NA], m5_q [NA], m7_q [NA];
  catrom_pkg::horn_t e2_3_q [NA], e1_3_q [NA], e0_3_q [NA];
  catrom_pkg::horn_t h4_q [NA], e1_4_q [NA], e0_4_q [NA];
  catrom_pkg::horn_t e1_5_q [NA], e0_5_q [NA];
  catrom_pkg::horn_t h6_q [NA], e0_6_q [NA], e0_7_q [NA];
  logic [UW-1:0] u2_q, u3_q, u4_q, u5_q, u6_q;
  logic [95:0] out_q;

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < NA; a++) begin
      if (en[2]) begin
        e3_q[a]   <= -catrom_pkg::horn_t'($signed(rd0_q[32*a +: 32]))
                     + 3 * catrom_pkg::horn_t'($signed(rd1_q[32*a +: 32]))
                     - 3 * catrom_pkg::horn_t'($signed(rd2_q[32*a +: 32]))
                     + catrom_pkg::horn_t'($signed(rd3_q[32*a +: 32]));
        e2_2_q[a] <= 2 * catrom_pkg::horn_t'($signed(rd0_q[32*a +: 32]))
                     - 5 * catrom_pkg::horn_t'($signed(rd1_q[32*a +: 32]))
                     + 4 * catrom_pkg::horn_t'($signed(rd2_q[32*a +: 32]))
                     - catrom_pkg::horn_t'($signed(rd3_q[32*a +: 32]));
        e1_2_q[a] <= catrom_pkg::horn_t'($signed(rd2_q[32*a +: 32]))
                     - catrom_pkg::horn_t'($signed(rd0_q[32*a +: 32]));
        e0_2_q[a] <= 2 * catrom_pkg::horn_t'($signed(rd1_q[32*a +: 32]));
      end
      if (en[3]) begin
        m3_q[a]   <= e3_q[a] * $signed({1'b0, u2_q});
        e2_3_q[a] <= e2_2_q[a];
        e1_3_q[a] <= e1_2_q[a];
        e0_3_q[a] <= e0_2_q[a];
      end
      if (en[4]) begin
        h4_q[a]   <= catrom_pkg::round_q16(m3_q[a]) + e2_3_q[a];
        e1_4_q[a] <= e1_3_q[a];
        e0_4_q[a] <= e0_3_q[a];
      end
      if (en[5]) begin
        m5_q[a]   <= h4_q[a] * $signed({1'b0, u4_q});
        e1_5_q[a] <= e1_4_q[a];
        e0_5_q[a] <= e0_4_q[a];
      end
      if (en[6]) begin
        h6_q[a]   <= catrom_pkg::round_q16(m5_q[a]) + e1_5_q[a];
        e0_6_q[a] <= e0_5_q[a];
      end
      if (en[7]) begin
        m7_q[a]   <= h6_q[a] * $signed({1'b0, u6_q});
        e0_7_q[a] <= e0_6_q[a];
      end
      if (en[8]) begin
        out_q[32*a +: 32] <= catrom_pkg::sat_half(catrom_pkg::round_q16(m7_q[a]) + e0_7_q[a]);
      end
    end
    if (en[2]) begin
      u2_q <= u1_q;
    end
    if (en[3]) begin
      u3_q <= u2_q;
    end
    if (en[4]) begin
      u4_q <= u3_q;
    end
    if (en[5]) begin
      u5_q <= u4_q;
    end
    if (en[6]) begin
      u6_q <= u5_q;
    end
  end

  assign m_tvalid = v_q[NS];
  assign m_tdata  = out_q;

  a_u_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[1] |-> (u1_q <= catrom_pkg::QOne))
    else $error("local parameter above one");

  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_c >= CW'(4)) && (32'(count_c) <= MAX_POINTS))
    else $error("point count outside clamp range");

  a_ready_on_bubble : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v_q[NS] |-> s_tready)
    else $error("input stalled with empty output stage");

endmodule
`default_nettype wire
